// File: rtl/rfipd_pkg.sv
// Shared types, codes and default sizes for the ring FIFO with indexed peek and delete.
`default_nettype none

package rfipd_pkg;

   localparam int DEPTH_DEFAULT      = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef enum logic [1:0] {
      ACTION_ENQUEUE = 2'd0,
      ACTION_DEQUEUE = 2'd1,
      ACTION_PEEK    = 2'd2,
      ACTION_DELETE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_BAD_POS = 2'd3
   } status_type;

   typedef enum logic {
      REG_CAPACITY = 1'b0,
      REG_NONE     = 1'b1
   } reg_index_type;

   typedef struct packed {
      action_type  action;
      logic [31:0] data_in;
      logic [6:0]  position;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] data_out;
      logic [6:0]  fill_count;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/rfipd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rfipd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/rfipd_ring_add.sv
// Ring address adder: base plus offset, wrapped at the buffer depth.
`default_nettype none

module rfipd_ring_add #(
   parameter int DEPTH = 64
) (
   input  wire logic [$clog2(DEPTH)-1:0] base,
   input  wire logic [$clog2(DEPTH)-1:0] offset,
   output logic      [$clog2(DEPTH)-1:0] sum
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

   logic [AW:0] raw;
   logic [AW:0] wrapped;

   always_comb begin
      raw     = {1'b0, base} + {1'b0, offset};
      wrapped = (raw >= DEPTH_W) ? (raw - DEPTH_W) : raw;
      sum     = wrapped[AW-1:0];
   end

endmodule

`default_nettype wire

// File: rtl/ring_fifo_with_indexed_peek_delete_top.sv
// Top level: sequencer, configuration port and storage of the ring FIFO.
`default_nettype none

// A request beat is taken when start is high and busy is low; each request gives
// exactly one result beat, shown on rsp_data for one cycle with rsp_valid high, and
// the receiver cannot stall it. Enqueue, a delete of the newest word and every failed
// request finish in the accept cycle and show their result in the next cycle. Dequeue
// and peek pass through a read state because of the registered memory read. A delete
// of an earlier word moves each later word one place toward the oldest by a read and
// a write through the single memory port pair, addressed by one shared ring adder.
// The user must write the capacity register only while idle; the block does not enforce it.
module ring_fifo_with_indexed_peek_delete_top
   import rfipd_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = ($clog2(DEPTH + 1) > 7) ? $clog2(DEPTH + 1) : 7;
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DEL_RD,
      ST_DEL_WR
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [CW-1:0] k_ff, k_in;
   logic [6:0]    cap_ff, cap_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  cfg_write;
   logic [CW-1:0]         cap_ext;
   logic [CW-1:0]         eff_cap;
   logic [CW-1:0]         pos_ext;
   logic [CW-1:0]         pos_m1;
   logic [CW-1:0]         k_next;
   logic                  pos_ok;
   logic [AW-1:0]         ring_off;
   logic [AW-1:0]         ring_sum;
   logic [AW-1:0]         wr_idx_inc;
   logic [AW-1:0]         wr_idx_dec;
   logic [AW-1:0]         rd_idx_inc;
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [DATA_WIDTH-1:0] ram_wr_data;
   logic [AW-1:0]         ram_rd_addr;
   logic [DATA_WIDTH-1:0] ram_rd_data;
   logic [DATA_WIDTH+31:0] in_wide;
   logic [DATA_WIDTH+31:0] out_wide;

   rfipd_ring_add #(
      .DEPTH(DEPTH)
   ) u_ring_add (
      .base   (rd_idx_ff),
      .offset (ring_off),
      .sum    (ring_sum)
   );

   rfipd_ram #(
      .WIDTH(DATA_WIDTH),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign accept    = start && (state_ff == ST_IDLE);
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (reg_index_type'(paddr[2]) == REG_CAPACITY) ? {25'd0, cap_ff} : 32'd0;

   always_comb begin
      cap_ext    = CW'(cap_ff);
      eff_cap    = (cap_ext == '0) ? CW'(1) : ((cap_ext > DEPTH_C) ? DEPTH_C : cap_ext);
      pos_ext    = CW'(req_data.position);
      pos_m1     = pos_ext - CW'(1);
      pos_ok     = (pos_ext != '0) && (pos_ext <= occ_ff);
      k_next     = k_ff + CW'(1);
      wr_idx_inc = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + AW'(1);
      wr_idx_dec = (wr_idx_ff == '0) ? LAST_IDX : wr_idx_ff - AW'(1);
      rd_idx_inc = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + AW'(1);
      in_wide    = {{DATA_WIDTH{1'b0}}, req_data.data_in};
      out_wide   = {32'd0, ram_rd_data};
   end

   always_comb begin
      state_in     = state_ff;
      rd_idx_in    = rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      occ_in       = occ_ff;
      k_in         = k_ff;
      cap_in       = cap_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ring_off     = pos_m1[AW-1:0];
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wr_idx_ff;
      ram_wr_data  = in_wide[DATA_WIDTH-1:0];
      ram_rd_addr  = ring_sum;

      if (cfg_write && (reg_index_type'(paddr[2]) == REG_CAPACITY)) begin
         cap_in = pwdata[6:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_data.action == ACTION_DEQUEUE) begin
               ram_rd_addr = rd_idx_ff;
            end
            if (accept) begin
               rsp_data_in.data_out   = 32'd0;
               rsp_data_in.fill_count = occ_ff[6:0];
               case (req_data.action)
                  ACTION_ENQUEUE: begin
                     rsp_valid_in = 1'b1;
                     if (occ_ff >= eff_cap) begin
                        rsp_data_in.status = STATUS_FULL;
                     end else begin
                        ram_wr_en              = 1'b1;
                        wr_idx_in              = wr_idx_inc;
                        occ_in                 = occ_ff + CW'(1);
                        rsp_data_in.status     = STATUS_OK;
                        rsp_data_in.fill_count = occ_in[6:0];
                     end
                  end
                  ACTION_DEQUEUE: begin
                     if (occ_ff == '0) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = STATUS_EMPTY;
                     end else begin
                        rd_idx_in = rd_idx_inc;
                        occ_in    = occ_ff - CW'(1);
                        state_in  = ST_READ;
                     end
                  end
                  ACTION_PEEK: begin
                     if (!pos_ok) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = STATUS_BAD_POS;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     if (!pos_ok) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.status = STATUS_BAD_POS;
                     end else if (pos_ext < occ_ff) begin
                        k_in     = pos_m1;
                        state_in = ST_DEL_RD;
                     end else begin
                        wr_idx_in              = wr_idx_dec;
                        occ_in                 = occ_ff - CW'(1);
                        rsp_valid_in           = 1'b1;
                        rsp_data_in.status     = STATUS_OK;
                        rsp_data_in.fill_count = occ_in[6:0];
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.status     = STATUS_OK;
            rsp_data_in.data_out   = out_wide[31:0];
            rsp_data_in.fill_count = occ_ff[6:0];
            state_in               = ST_IDLE;
         end
         ST_DEL_RD: begin
            ring_off    = k_next[AW-1:0];
            ram_rd_addr = ring_sum;
            state_in    = ST_DEL_WR;
         end
         ST_DEL_WR: begin
            ring_off    = k_ff[AW-1:0];
            ram_wr_en   = 1'b1;
            ram_wr_addr = ring_sum;
            ram_wr_data = ram_rd_data;
            k_in        = k_next;
            if ({1'b0, k_next} + (CW+1)'(1) < {1'b0, occ_ff}) begin
               state_in = ST_DEL_RD;
            end else begin
               wr_idx_in              = wr_idx_dec;
               occ_in                 = occ_ff - CW'(1);
               rsp_valid_in           = 1'b1;
               rsp_data_in.status     = STATUS_OK;
               rsp_data_in.data_out   = 32'd0;
               rsp_data_in.fill_count = occ_in[6:0];
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         occ_ff       <= '0;
         k_ff         <= '0;
         cap_ff       <= 7'd64;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         occ_ff       <= occ_in;
         k_ff         <= k_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // While a request is in progress no result beat of it has gone out yet.
   a_busy_no_beat: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("result beat while busy");

   // An accepted request either answers at once or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted request neither answered nor in progress");

   // The word count never exceeds the built depth.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= DEPTH_C)
      else $error("occupancy beyond depth");

   // A delete that moves words always returns to idle with one word fewer.
   a_delete_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEL_WR && state_in == ST_IDLE) |=> (occ_ff == $past(occ_ff) - CW'(1)))
      else $error("delete did not remove exactly one word");
`endif

endmodule

`default_nettype wire

// File: sim/ring_fifo_with_indexed_peek_delete_top_tb.sv
// Testbench for the ring FIFO: phased random requests, a ring FIFO predictor, and result checks.
module ring_fifo_with_indexed_peek_delete_top_tb;
   import rfipd_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   logic        clock   = 1'b0;
   logic        reset   = 1'b1;
   logic        start   = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        psel    = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite  = 1'b0;
   logic [2:0]  paddr   = '0;
   logic [31:0] pwdata  = '0;
   logic [31:0] prdata;
   logic        pready;

   req_type     pending_requests[$];
   rsp_type     expected_responses[$];
   logic        feed_enable = 1'b0;
   int          gap_cycles = 0;
   int          burst_left = 0;
   int          failures = 0;
   int          cycle_count = 0;

   logic [31:0] fifo_words [0:DEPTH_DEFAULT-1];
   logic [5:0]  fifo_head = '0;
   logic [5:0]  fifo_tail = '0;
   logic [6:0]  fifo_count = '0;
   logic [6:0]  capacity_reg = 7'd64;

   ring_fifo_with_indexed_peek_delete_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   function automatic logic [6:0] usable_capacity(logic [6:0] cap);
      if (cap == 7'd0) return 7'd1;
      if (cap > 7'(DEPTH_DEFAULT)) return 7'(DEPTH_DEFAULT);
      return cap;
   endfunction

   function automatic rsp_type fifo_response(req_type r);
      rsp_type    result;
      logic [5:0] slot;
      int         k;
      result.status   = STATUS_OK;
      result.data_out = '0;
      case (r.action)
         ACTION_ENQUEUE: begin
            if (fifo_count >= usable_capacity(capacity_reg)) begin
               result.status = STATUS_FULL;
            end else begin
               fifo_words[fifo_tail] = r.data_in;
               fifo_tail  = fifo_tail + 6'd1;
               fifo_count = fifo_count + 7'd1;
            end
         end
         ACTION_DEQUEUE: begin
            if (fifo_count == 7'd0) begin
               result.status = STATUS_EMPTY;
            end else begin
               result.data_out = fifo_words[fifo_head];
               fifo_head  = fifo_head + 6'd1;
               fifo_count = fifo_count - 7'd1;
            end
         end
         ACTION_PEEK: begin
            if (r.position == 7'd0 || r.position > fifo_count) begin
               result.status = STATUS_BAD_POS;
            end else begin
               slot = fifo_head + r.position[5:0] - 6'd1;
               result.data_out = fifo_words[slot];
            end
         end
         default: begin
            if (r.position == 7'd0 || r.position > fifo_count) begin
               result.status = STATUS_BAD_POS;
            end else begin
               for (k = int'(r.position) - 1; k + 1 < int'(fifo_count); k++) begin
                  slot = fifo_head + 6'(k);
                  fifo_words[slot] = fifo_words[slot + 6'd1];
               end
               fifo_tail  = fifo_tail - 6'd1;
               fifo_count = fifo_count - 7'd1;
            end
         end
      endcase
      result.fill_count = fifo_count;
      return result;
   endfunction

   // Request driver: holds each beat until accepted, then waits its drawn gap.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_cycles = 0;
      end else begin
         if (start && !busy) begin
            expected_responses.push_back(fifo_response(req_data));
         end
         if (!start || !busy) begin
            if (gap_cycles != 0) begin
               start <= 1'b0;
               gap_cycles = gap_cycles - 1;
            end else if (feed_enable && pending_requests.size() != 0) begin
               start    <= 1'b1;
               req_data <= pending_requests.pop_front();
               if (burst_left != 0) begin
                  burst_left = burst_left - 1;
               end else if ($urandom_range(0, 9) == 0) begin
                  burst_left = $urandom_range(5, 30);
               end else begin
                  gap_cycles = $urandom_range(0, 5);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_responses.size() == 0) begin
            $display("%0t: result beat with none expected: status %0d data %h count %0d",
                     $time, rsp_data.status, rsp_data.data_out, rsp_data.fill_count);
            failures++;
         end else begin
            want = expected_responses.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_data.status);
               failures++;
            end
            if (rsp_data.data_out !== want.data_out) begin
               $display("%0t: data_out expected %h actual %h", $time, want.data_out,
                        rsp_data.data_out);
               failures++;
            end
            if (rsp_data.fill_count !== want.fill_count) begin
               $display("%0t: fill_count expected %0d actual %0d", $time, want.fill_count,
                        rsp_data.fill_count);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic write_capacity(logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_CAPACITY, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      capacity_reg = value[6:0];
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic add_request(action_type act, logic [31:0] word, logic [6:0] pos);
      req_type r;
      r.action   = act;
      r.data_in  = word;
      r.position = pos;
      pending_requests.push_back(r);
   endtask

   task automatic run_requests();
      @(posedge clock);
      feed_enable <= 1'b1;
      @(posedge clock);
      do @(posedge clock);
      while (pending_requests.size() != 0 || expected_responses.size() != 0 || start || busy);
      feed_enable <= 1'b0;
      repeat (4) @(posedge clock);
   endtask

   // Mostly meaningful requests: positions track the planned fill, the tide of
   // enqueues and dequeues shifts every few dozen beats, and some beats are noise.
   task automatic queue_random_requests(int n);
      int         i;
      int         roll;
      int         tide;
      int         enq_cut;
      int         deq_cut;
      int         peek_cut;
      logic [6:0] plan_count;
      action_type act;
      logic [6:0] pos;
      plan_count = fifo_count;
      tide = $urandom_range(0, 2);
      for (i = 0; i < n; i++) begin
         if (i % 40 == 39) tide = $urandom_range(0, 2);
         case (tide)
            0:       begin enq_cut = 55; deq_cut = 65; peek_cut = 82; end
            1:       begin enq_cut = 10; deq_cut = 55; peek_cut = 75; end
            default: begin enq_cut = 30; deq_cut = 55; peek_cut = 78; end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            act = action_type'($urandom_range(0, 3));
            pos = 7'($urandom_range(0, 127));
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < enq_cut) act = ACTION_ENQUEUE;
            else if (roll < deq_cut) act = ACTION_DEQUEUE;
            else if (roll < peek_cut) act = ACTION_PEEK;
            else act = ACTION_DELETE;
            roll = $urandom_range(0, 9);
            if (roll == 0) pos = 7'd0;
            else if (roll == 1) pos = plan_count + 7'd1;
            else if (plan_count == 7'd0) pos = 7'd1;
            else if (roll == 2) pos = plan_count;
            else pos = 7'($urandom_range(1, plan_count));
         end
         add_request(act, $urandom(), pos);
         case (act)
            ACTION_ENQUEUE:
               if (plan_count < usable_capacity(capacity_reg)) plan_count++;
            ACTION_DEQUEUE:
               if (plan_count != 7'd0) plan_count--;
            ACTION_DELETE:
               if (pos != 7'd0 && pos <= plan_count) plan_count--;
            default: ;
         endcase
      end
   endtask

   initial begin : stimulus
      int phase;
      int i;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      write_capacity(32'd64);
      add_request(ACTION_DEQUEUE, 32'h1111_1111, 7'd0);
      add_request(ACTION_PEEK,    32'h0, 7'd1);
      add_request(ACTION_DELETE,  32'h0, 7'd0);
      add_request(ACTION_ENQUEUE, 32'h0000_0000, 7'd0);
      add_request(ACTION_ENQUEUE, 32'hFFFF_FFFF, 7'd127);
      add_request(ACTION_ENQUEUE, 32'hA5A5_A5A5, 7'd0);
      add_request(ACTION_ENQUEUE, 32'h5A5A_5A5A, 7'd0);
      add_request(ACTION_PEEK,    32'h0, 7'd0);
      add_request(ACTION_PEEK,    32'h0, 7'd1);
      add_request(ACTION_PEEK,    32'h0, 7'd4);
      add_request(ACTION_PEEK,    32'h0, 7'd5);
      add_request(ACTION_PEEK,    32'h0, 7'd127);
      add_request(ACTION_DELETE,  32'h0, 7'd2);
      add_request(ACTION_PEEK,    32'h0, 7'd2);
      add_request(ACTION_DELETE,  32'h0, 7'd3);
      add_request(ACTION_DELETE,  32'h0, 7'd1);
      add_request(ACTION_DEQUEUE, 32'h0, 7'd0);
      add_request(ACTION_DEQUEUE, 32'h0, 7'd0);
      add_request(ACTION_ENQUEUE, 32'h1234_5678, 7'd0);
      run_requests();

      write_capacity(32'd1);
      add_request(ACTION_ENQUEUE, 32'hDEAD_BEEF, 7'd0);
      add_request(ACTION_ENQUEUE, 32'hCAFE_F00D, 7'd0);
      add_request(ACTION_PEEK,    32'h0, 7'd1);
      add_request(ACTION_DELETE,  32'h0, 7'd1);
      add_request(ACTION_DELETE,  32'h0, 7'd1);
      add_request(ACTION_ENQUEUE, 32'h8000_0001, 7'd0);
      add_request(ACTION_DEQUEUE, 32'h0, 7'd0);
      run_requests();

      // Fill to fifty words under the full capacity, then lower the capacity under the fill.
      write_capacity(32'd64);
      for (i = 0; i < 50; i++) add_request(ACTION_ENQUEUE, $urandom(), 7'd0);
      run_requests();
      write_capacity(32'hFFFF_FF86);
      queue_random_requests(60);
      run_requests();

      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       write_capacity(32'd127);
            1:       write_capacity(32'd0);
            2:       write_capacity(32'd64);
            3:       write_capacity(32'd2);
            4:       write_capacity(32'd64);
            5:       write_capacity(32'd33);
            6:       write_capacity($urandom_range(0, 127));
            default: write_capacity(32'd64);
         endcase
         queue_random_requests(90);
         run_requests();
      end

      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: ring_fifo_with_indexed_peek_delete_top.f
rtl/rfipd_pkg.sv
rtl/rfipd_ram.sv
rtl/rfipd_ring_add.sv
rtl/ring_fifo_with_indexed_peek_delete_top.sv
sim/ring_fifo_with_indexed_peek_delete_top_tb.sv
